/* sv/i2c_master_bit_sequencer_unit_defines.svh */
// Assertion macros shared by the I2C master bit sequencer modules.
`ifndef I2C_MASTER_BIT_SEQUENCER_UNIT_DEFINES_SVH
`define I2C_MASTER_BIT_SEQUENCER_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define I2CMS_ASSERT_SAME(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define I2CMS_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error(msg);

`else

`define I2CMS_ASSERT_SAME(label, clk, rst, pre, post, msg)
`define I2CMS_ASSERT_NEXT(label, clk, rst, pre, post, msg)

`endif

`endif

/* sv/i2cms_pkg.sv */
// Types and constants shared by the I2C master bit sequencer modules.
`timescale 1ns / 1ps

package i2cms_pkg;

  // Bits per byte on the bus and the width of the bit counter.
  localparam int DATA_BITS = 8;
  localparam int BIT_CNT_W = $clog2(DATA_BITS + 1);

  // Depth of the item and result queues.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Register reset values.
  localparam logic [7:0]  HALF_PERIOD_RESET = 8'd5;
  localparam logic [15:0] ACK_WAIT_RESET    = 16'd250;

  // Register indexes on the configuration port.
  localparam logic REG_HALF_PERIOD = 1'b0;
  localparam logic REG_ACK_WAIT    = 1'b1;

  // Command codes.
  typedef enum logic [2:0] {
    CMD_NONE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_WRITE = 3'd3,
    CMD_READ  = 3'd4
  } cmd_e;

  // Bus phases of the sequencer.
  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START_A   = 4'd1,
    PH_START_B   = 4'd2,
    PH_STOP_LOW  = 4'd3,
    PH_STOP_HIGH = 4'd4,
    PH_STOP_REL  = 4'd5,
    PH_WR_LOW    = 4'd6,
    PH_WR_HIGH   = 4'd7,
    PH_ACK_LOW   = 4'd8,
    PH_ACK_HIGH  = 4'd9,
    PH_ACK_POLL  = 4'd10,
    PH_RD_LOW    = 4'd11,
    PH_RD_HIGH   = 4'd12,
    PH_RACK_LOW  = 4'd13,
    PH_RACK_HIGH = 4'd14,
    PH_RACK_END  = 4'd15
  } phase_e;

  // One tick item as it arrives.
  typedef struct packed {
    logic [2:0] command;
    logic [7:0] write_data;
    logic       send_nack;
    logic       sda_in;
  } item_t;

  // One tick item after classification.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] write_data;
    logic       send_nack;
    logic       sda_in;
  } work_t;

  // One result item.
  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       no_ack;
  } result_t;

  // Configuration registers.
  typedef struct packed {
    logic [7:0]  half_period_ticks;
    logic [15:0] ack_wait_limit;
  } cfg_t;

endpackage

/* sv/i2c_master_bit_sequencer_unit.sv */
// Top level of the I2C master bit sequencer: configuration registers and the two queues.
`timescale 1ns / 1ps

// I2C master that drives open-drain SCL and SDA levels, one time-base tick per item.
// Each item is one tick and may carry a start, stop, write-byte or read-byte command,
// which is taken only while no command is in progress. Every tick gives exactly one
// result item with the drive levels, busy, a done pulse, the last read byte and the
// no-ack flag. The block takes one item per clock cycle: the sequencer takes one tick
// from the item queue in each cycle that the result queue has room. A result reaches
// the result ports after its item is registered in the item queue and then in the
// result queue. Register half_period_ticks sits at byte address 0 and ack_wait_limit
// at byte address 4; write them only while no items are in flight.
module i2c_master_bit_sequencer_unit (
  input  logic               clk,
  input  logic               rst,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Tick items
  input  i2cms_pkg::item_t   item,
  input  logic               push,
  output logic               full,
  // Result items
  output i2cms_pkg::result_t result,
  output logic               empty,
  input  logic               pop
);

  i2cms_pkg::cfg_t    cfg;
  i2cms_pkg::work_t   work;
  logic               work_valid;
  logic               work_take;
  logic               res_full;
  logic               res_push;
  i2cms_pkg::result_t res_out;
  logic               cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers; the low address bits are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= i2cms_pkg::HALF_PERIOD_RESET;
      cfg.ack_wait_limit    <= i2cms_pkg::ACK_WAIT_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        i2cms_pkg::REG_HALF_PERIOD: cfg.half_period_ticks <= pwdata[7:0];
        i2cms_pkg::REG_ACK_WAIT:    cfg.ack_wait_limit    <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[2])
      i2cms_pkg::REG_HALF_PERIOD: prdata = {24'd0, cfg.half_period_ticks};
      i2cms_pkg::REG_ACK_WAIT:    prdata = {16'd0, cfg.ack_wait_limit};
      default:                    prdata = '0;
    endcase
  end

  i2cms_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .push       (push),
    .full       (full),
    .work       (work),
    .work_valid (work_valid),
    .work_take  (work_take)
  );

  i2cms_seq u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .work       (work),
    .work_valid (work_valid),
    .work_take  (work_take),
    .res_full   (res_full),
    .res_push   (res_push),
    .res_out    (res_out)
  );

  i2cms_resq u_resq (
    .clk      (clk),
    .rst      (rst),
    .res_in   (res_out),
    .res_push (res_push),
    .res_full (res_full),
    .result   (result),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

/* sv/i2cms_front.sv */
// Front end: takes tick items, decodes the command and queues them for the sequencer.
`timescale 1ns / 1ps
`include "i2c_master_bit_sequencer_unit_defines.svh"

module i2cms_front (
  input  logic             clk,
  input  logic             rst,
  input  i2cms_pkg::item_t item,
  input  logic             push,
  output logic             full,
  output i2cms_pkg::work_t work,
  output logic             work_valid,
  input  logic             work_take
);

  i2cms_pkg::work_t                       entry [i2cms_pkg::QUEUE_DEPTH];
  logic [i2cms_pkg::QUEUE_PTR_W-1:0]      wr_ptr;
  logic [i2cms_pkg::QUEUE_PTR_W-1:0]      rd_ptr;
  logic [i2cms_pkg::QUEUE_CNT_W-1:0]      count;
  logic                                   do_push;
  logic                                   do_pop;
  i2cms_pkg::work_t                       decoded;

  // Codes outside the command set are treated as no command.
  always_comb begin
    decoded.write_data = item.write_data;
    decoded.send_nack  = item.send_nack;
    decoded.sda_in     = item.sda_in;
    case (item.command)
      i2cms_pkg::CMD_START: decoded.cmd = i2cms_pkg::CMD_START;
      i2cms_pkg::CMD_STOP:  decoded.cmd = i2cms_pkg::CMD_STOP;
      i2cms_pkg::CMD_WRITE: decoded.cmd = i2cms_pkg::CMD_WRITE;
      i2cms_pkg::CMD_READ:  decoded.cmd = i2cms_pkg::CMD_READ;
      default:              decoded.cmd = i2cms_pkg::CMD_NONE;
    endcase
  end

  assign full       = (count == i2cms_pkg::QUEUE_CNT_W'(i2cms_pkg::QUEUE_DEPTH));
  assign work_valid = (count != '0);
  assign work       = entry[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = work_take && work_valid;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= decoded;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == i2cms_pkg::QUEUE_PTR_W'(i2cms_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == i2cms_pkg::QUEUE_PTR_W'(i2cms_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // The fill count never passes the queue depth.
  `I2CMS_ASSERT_SAME(a_front_count, clk, rst, 1'b1, count <= i2cms_pkg::QUEUE_CNT_W'(i2cms_pkg::QUEUE_DEPTH), "item queue overflow")

endmodule

/* sv/i2cms_resq.sv */
// Result queue between the sequencer and the result port.
`timescale 1ns / 1ps
`include "i2c_master_bit_sequencer_unit_defines.svh"

module i2cms_resq (
  input  logic               clk,
  input  logic               rst,
  input  i2cms_pkg::result_t res_in,
  input  logic               res_push,
  output logic               res_full,
  output i2cms_pkg::result_t result,
  output logic               empty,
  input  logic               pop
);

  i2cms_pkg::result_t                     entry [i2cms_pkg::QUEUE_DEPTH];
  logic [i2cms_pkg::QUEUE_PTR_W-1:0]      wr_ptr;
  logic [i2cms_pkg::QUEUE_PTR_W-1:0]      rd_ptr;
  logic [i2cms_pkg::QUEUE_CNT_W-1:0]      count;
  logic                                   do_push;
  logic                                   do_pop;

  assign res_full = (count == i2cms_pkg::QUEUE_CNT_W'(i2cms_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign result   = entry[rd_ptr];
  assign do_push  = res_push && !res_full;
  assign do_pop   = pop && !empty;

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry[wr_ptr] <= res_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == i2cms_pkg::QUEUE_PTR_W'(i2cms_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == i2cms_pkg::QUEUE_PTR_W'(i2cms_pkg::QUEUE_DEPTH - 1)) ?
                  '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  // The fill count never passes the queue depth.
  `I2CMS_ASSERT_SAME(a_resq_count, clk, rst, 1'b1, count <= i2cms_pkg::QUEUE_CNT_W'(i2cms_pkg::QUEUE_DEPTH), "result queue overflow")

endmodule

/* sv/i2cms_seq.sv */
// Back end: the bus phase sequencer that turns each tick into one result item.
`timescale 1ns / 1ps
`include "i2c_master_bit_sequencer_unit_defines.svh"

module i2cms_seq (
  input  logic               clk,
  input  logic               rst,
  input  i2cms_pkg::cfg_t    cfg,
  input  i2cms_pkg::work_t   work,
  input  logic               work_valid,
  output logic               work_take,
  input  logic               res_full,
  output logic               res_push,
  output i2cms_pkg::result_t res_out
);

  localparam int BW = i2cms_pkg::BIT_CNT_W;
  localparam int DB = i2cms_pkg::DATA_BITS;

  i2cms_pkg::phase_e phase, phase_next;
  logic [BW-1:0]     bit_count, bit_count_next;
  logic [DB-1:0]     shift_byte, shift_byte_next;
  logic [7:0]        tick_count, tick_count_next;
  logic [15:0]       wait_count, wait_count_next;
  logic              scl_drive, scl_drive_next;
  logic              sda_drive, sda_drive_next;
  logic              nack_pending, nack_pending_next;
  logic [DB-1:0]     last_read, last_read_next;
  logic              noack_flag, noack_flag_next;
  logic              done;
  logic              step;
  logic [7:0]        half_eff;
  logic [15:0]       limit_eff;
  logic [7:0]        tick_inc;
  logic [15:0]       wait_inc;
  logic [BW-1:0]     bit_inc;
  logic [DB-1:0]     shift_wr;
  logic [DB-1:0]     shift_rd;

  // One tick is taken whenever one waits and the result queue has room.
  assign step      = work_valid && !res_full;
  assign work_take = step;
  assign res_push  = step;

  // Zero register values behave as one.
  assign half_eff  = (cfg.half_period_ticks == '0) ? 8'd1 : cfg.half_period_ticks;
  assign limit_eff = (cfg.ack_wait_limit == '0) ? 16'd1 : cfg.ack_wait_limit;
  assign tick_inc  = tick_count + 8'd1;
  assign wait_inc  = wait_count + 16'd1;
  assign bit_inc   = bit_count + 1'b1;
  assign shift_wr  = {shift_byte[DB-2:0], 1'b0};
  assign shift_rd  = {shift_byte[DB-2:0], work.sda_in};

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= i2cms_pkg::PH_IDLE;
      bit_count    <= '0;
      shift_byte   <= '0;
      tick_count   <= '0;
      wait_count   <= '0;
      scl_drive    <= 1'b1;
      sda_drive    <= 1'b1;
      nack_pending <= 1'b0;
      last_read    <= '0;
      noack_flag   <= 1'b0;
    end else if (step) begin
      phase        <= phase_next;
      bit_count    <= bit_count_next;
      shift_byte   <= shift_byte_next;
      tick_count   <= tick_count_next;
      wait_count   <= wait_count_next;
      scl_drive    <= scl_drive_next;
      sda_drive    <= sda_drive_next;
      nack_pending <= nack_pending_next;
      last_read    <= last_read_next;
      noack_flag   <= noack_flag_next;
    end
  end

  // Next state: commands in idle, ACK polling, and half-period timed phases.
  always_comb begin
    phase_next        = phase;
    bit_count_next    = bit_count;
    shift_byte_next   = shift_byte;
    tick_count_next   = tick_count;
    wait_count_next   = wait_count;
    scl_drive_next    = scl_drive;
    sda_drive_next    = sda_drive;
    nack_pending_next = nack_pending;
    last_read_next    = last_read;
    noack_flag_next   = noack_flag;
    done              = 1'b0;
    case (phase)
      i2cms_pkg::PH_IDLE: begin
        case (work.cmd)
          i2cms_pkg::CMD_START: begin
            phase_next      = i2cms_pkg::PH_START_A;
            scl_drive_next  = 1'b1;
            sda_drive_next  = 1'b1;
            tick_count_next = '0;
          end
          i2cms_pkg::CMD_STOP: begin
            phase_next      = i2cms_pkg::PH_STOP_LOW;
            scl_drive_next  = 1'b0;
            sda_drive_next  = 1'b0;
            tick_count_next = '0;
          end
          i2cms_pkg::CMD_WRITE: begin
            shift_byte_next = work.write_data;
            bit_count_next  = '0;
            wait_count_next = '0;
            noack_flag_next = 1'b0;
            phase_next      = i2cms_pkg::PH_WR_LOW;
            scl_drive_next  = 1'b0;
            sda_drive_next  = work.write_data[DB-1];
            tick_count_next = '0;
          end
          i2cms_pkg::CMD_READ: begin
            shift_byte_next   = '0;
            bit_count_next    = '0;
            nack_pending_next = work.send_nack;
            phase_next        = i2cms_pkg::PH_RD_LOW;
            scl_drive_next    = 1'b0;
            sda_drive_next    = 1'b1;
            tick_count_next   = '0;
          end
          default: begin
          end
        endcase
      end
      i2cms_pkg::PH_ACK_POLL: begin
        // The slave acknowledges by pulling SDA low; otherwise count toward timeout.
        if (!work.sda_in) begin
          scl_drive_next  = 1'b0;
          phase_next      = i2cms_pkg::PH_IDLE;
          tick_count_next = '0;
          done            = 1'b1;
        end else begin
          wait_count_next = wait_inc;
          if (wait_inc >= limit_eff) begin
            noack_flag_next = 1'b1;
            phase_next      = i2cms_pkg::PH_STOP_LOW;
            scl_drive_next  = 1'b0;
            sda_drive_next  = 1'b0;
            tick_count_next = '0;
          end
        end
      end
      default: begin
        tick_count_next = tick_inc;
        if (tick_inc >= half_eff) begin
          // Half period over: move to the next bus phase.
          tick_count_next = '0;
          case (phase)
            i2cms_pkg::PH_START_A: begin
              phase_next     = i2cms_pkg::PH_START_B;
              scl_drive_next = 1'b1;
              sda_drive_next = 1'b0;
            end
            i2cms_pkg::PH_START_B: begin
              scl_drive_next = 1'b0;
              phase_next     = i2cms_pkg::PH_IDLE;
              done           = 1'b1;
            end
            i2cms_pkg::PH_STOP_LOW: begin
              phase_next     = i2cms_pkg::PH_STOP_HIGH;
              scl_drive_next = 1'b1;
              sda_drive_next = 1'b0;
            end
            i2cms_pkg::PH_STOP_HIGH: begin
              phase_next     = i2cms_pkg::PH_STOP_REL;
              scl_drive_next = 1'b1;
              sda_drive_next = 1'b1;
            end
            i2cms_pkg::PH_STOP_REL: begin
              phase_next = i2cms_pkg::PH_IDLE;
              done       = 1'b1;
            end
            i2cms_pkg::PH_WR_LOW: begin
              phase_next     = i2cms_pkg::PH_WR_HIGH;
              scl_drive_next = 1'b1;
            end
            i2cms_pkg::PH_WR_HIGH: begin
              shift_byte_next = shift_wr;
              bit_count_next  = bit_inc;
              scl_drive_next  = 1'b0;
              if (bit_inc >= BW'(DB)) begin
                phase_next     = i2cms_pkg::PH_ACK_LOW;
                sda_drive_next = 1'b1;
              end else begin
                phase_next     = i2cms_pkg::PH_WR_LOW;
                sda_drive_next = shift_wr[DB-1];
              end
            end
            i2cms_pkg::PH_ACK_LOW: begin
              phase_next     = i2cms_pkg::PH_ACK_HIGH;
              scl_drive_next = 1'b1;
              sda_drive_next = 1'b1;
            end
            i2cms_pkg::PH_ACK_HIGH: begin
              phase_next     = i2cms_pkg::PH_ACK_POLL;
              scl_drive_next = 1'b1;
              sda_drive_next = 1'b1;
            end
            i2cms_pkg::PH_RD_LOW: begin
              phase_next     = i2cms_pkg::PH_RD_HIGH;
              scl_drive_next = 1'b1;
              sda_drive_next = 1'b1;
            end
            i2cms_pkg::PH_RD_HIGH: begin
              // Sample the data bit at the end of the SCL high half.
              shift_byte_next = shift_rd;
              bit_count_next  = bit_inc;
              scl_drive_next  = 1'b0;
              if (bit_inc >= BW'(DB)) begin
                last_read_next = shift_rd;
                phase_next     = i2cms_pkg::PH_RACK_LOW;
                sda_drive_next = nack_pending;
              end else begin
                phase_next     = i2cms_pkg::PH_RD_LOW;
                sda_drive_next = 1'b1;
              end
            end
            i2cms_pkg::PH_RACK_LOW: begin
              phase_next     = i2cms_pkg::PH_RACK_HIGH;
              scl_drive_next = 1'b1;
            end
            i2cms_pkg::PH_RACK_HIGH: begin
              phase_next     = i2cms_pkg::PH_RACK_END;
              scl_drive_next = 1'b0;
            end
            i2cms_pkg::PH_RACK_END: begin
              phase_next = i2cms_pkg::PH_IDLE;
              done       = 1'b1;
            end
            default: begin
              phase_next = i2cms_pkg::PH_IDLE;
            end
          endcase
        end
      end
    endcase
  end

  // Result item for this tick, built from the state after it.
  always_comb begin
    res_out.scl_level = scl_drive_next;
    res_out.sda_level = sda_drive_next;
    res_out.busy_res  = (phase_next != i2cms_pkg::PH_IDLE);
    res_out.done_res  = done;
    res_out.read_data = last_read_next;
    res_out.no_ack    = noack_flag_next;
  end

  // A completed command always leaves the sequencer idle.
  `I2CMS_ASSERT_NEXT(a_seq_done_idle, clk, rst, step && done, phase == i2cms_pkg::PH_IDLE, "done without returning to idle")

  // The bit counter never runs past one byte.
  `I2CMS_ASSERT_SAME(a_seq_bit_range, clk, rst, 1'b1, bit_count <= BW'(DB), "bit counter out of range")

  // An accepted write clears the no-ack flag and starts shifting.
  `I2CMS_ASSERT_NEXT(a_seq_write_start, clk, rst, step && (phase == i2cms_pkg::PH_IDLE) && (work.cmd == i2cms_pkg::CMD_WRITE), !noack_flag && (phase == i2cms_pkg::PH_WR_LOW), "write did not start cleanly")

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the I2C master bit sequencer: predicted bus levels vs. results.
`timescale 1ns / 1ps

module tb_top;

  // Command codes outside the defined set; the block treats them as no command.
  localparam logic [2:0] CMD_RSVD5 = 3'd5;
  localparam logic [2:0] CMD_RSVD6 = 3'd6;
  localparam logic [2:0] CMD_RSVD7 = 3'd7;

  // Bus levels of an idle block that still holds both lines released.
  localparam i2cms_pkg::result_t IDLE_RELEASED = '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0};

  // One row of the directed table: the first tick, the command carried by the follow-up
  // ticks while busy, and the levels expected on the first tick where they are obvious.
  typedef struct {
    i2cms_pkg::item_t   first;
    logic [2:0]         busy_cmd;
    logic               typed;
    i2cms_pkg::result_t want;
  } dir_row_t;

  // One random section: register values, length in ticks, slave no-ack odds, stall-free flag.
  typedef struct {
    logic [7:0]  half;
    logic [15:0] limit;
    int          ticks;
    int          nak_pct;
    logic        calm;
  } bus_mode_t;

  bus_mode_t bus_modes [8] = '{
    '{8'd1,   16'd1,    150, 30, 1'b0},
    '{8'd2,   16'd3,    180, 30, 1'b0},
    '{8'd0,   16'd0,    120, 30, 1'b1},
    '{8'd3,   16'd12,   180, 20, 1'b0},
    '{8'd1,   16'hFFFF, 150,  0, 1'b1},
    '{8'd255, 16'd2,     60, 50, 1'b0},
    '{8'd5,   16'd250,  180, 10, 1'b0},
    '{8'd2,   16'd1,    180, 40, 1'b0}
  };

  // DUT connections, all inputs driven to known values from time zero.
  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [2:0]         paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;
  i2cms_pkg::item_t   item    = '0;
  logic               push    = 1'b0;
  logic               full;
  i2cms_pkg::result_t result;
  logic               empty;
  logic               pop     = 1'b0;

  // Sequencer state as predicted by the testbench.
  logic [7:0]        half_cfg  = i2cms_pkg::HALF_PERIOD_RESET;
  logic [15:0]       limit_cfg = i2cms_pkg::ACK_WAIT_RESET;
  i2cms_pkg::phase_e ph        = i2cms_pkg::PH_IDLE;
  logic [3:0]        nbits     = '0;
  logic [7:0]        sreg      = '0;
  logic [7:0]        tcnt      = '0;
  logic [15:0]       wcnt      = '0;
  logic              scl_d     = 1'b1;
  logic              sda_d     = 1'b1;
  logic              nack_p    = 1'b0;
  logic [7:0]        last_rd   = '0;
  logic              noack     = 1'b0;

  // Expected bus levels, oldest first, and stimulus bookkeeping.
  i2cms_pkg::result_t levels_q [$];
  i2cms_pkg::item_t   cmd_plan [$];
  logic               slave_ok   = 1'b1;
  int                 nak_pct    = 0;
  logic               stall_free = 1'b0;
  int                 errors     = 0;

  i2c_master_bit_sequencer_unit u_dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .item    (item),
    .push    (push),
    .full    (full),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Counts a mismatch and reports only the first few.
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, name, want, got);
    end
  endfunction

  function automatic int pick_gap();
    return stall_free ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic i2cms_pkg::item_t rnd_item();
    return i2cms_pkg::item_t'($bits(i2cms_pkg::item_t)'($urandom));
  endfunction

  // Moves to a new bus phase with the given line drives and restarts the tick counter.
  function automatic void go_phase(i2cms_pkg::phase_e p, logic scl, logic sda);
    ph    = p;
    scl_d = scl;
    sda_d = sda;
    tcnt  = '0;
  endfunction

  // Advances the predicted sequencer by one tick and returns the bus levels after it.
  function automatic i2cms_pkg::result_t sequencer_tick(i2cms_pkg::item_t it);
    logic [7:0]         half;
    logic [15:0]        lim;
    logic               done;
    i2cms_pkg::result_t r;
    half = (half_cfg == '0) ? 8'd1 : half_cfg;
    lim  = (limit_cfg == '0) ? 16'd1 : limit_cfg;
    done = 1'b0;
    if (ph == i2cms_pkg::PH_IDLE) begin
      // Commands are only taken while idle.
      case (it.command)
        i2cms_pkg::CMD_START: go_phase(i2cms_pkg::PH_START_A, 1'b1, 1'b1);
        i2cms_pkg::CMD_STOP:  go_phase(i2cms_pkg::PH_STOP_LOW, 1'b0, 1'b0);
        i2cms_pkg::CMD_WRITE: begin
          sreg  = it.write_data;
          nbits = '0;
          wcnt  = '0;
          noack = 1'b0;
          go_phase(i2cms_pkg::PH_WR_LOW, 1'b0, sreg[i2cms_pkg::DATA_BITS-1]);
        end
        i2cms_pkg::CMD_READ: begin
          sreg   = '0;
          nbits  = '0;
          nack_p = it.send_nack;
          go_phase(i2cms_pkg::PH_RD_LOW, 1'b0, 1'b1);
        end
        default: ;
      endcase
    end else if (ph == i2cms_pkg::PH_ACK_POLL) begin
      // Each poll tick samples SDA; too many high samples end in a stop.
      if (!it.sda_in) begin
        scl_d = 1'b0;
        ph    = i2cms_pkg::PH_IDLE;
        tcnt  = '0;
        done  = 1'b1;
      end else begin
        wcnt = wcnt + 16'd1;
        if (wcnt >= lim) begin
          noack = 1'b1;
          go_phase(i2cms_pkg::PH_STOP_LOW, 1'b0, 1'b0);
        end
      end
    end else begin
      // Timed phases move on when the half period has elapsed.
      tcnt = tcnt + 8'd1;
      if (tcnt >= half) begin
        case (ph)
          i2cms_pkg::PH_START_A:   go_phase(i2cms_pkg::PH_START_B, 1'b1, 1'b0);
          i2cms_pkg::PH_START_B: begin
            scl_d = 1'b0;
            ph    = i2cms_pkg::PH_IDLE;
            tcnt  = '0;
            done  = 1'b1;
          end
          i2cms_pkg::PH_STOP_LOW:  go_phase(i2cms_pkg::PH_STOP_HIGH, 1'b1, 1'b0);
          i2cms_pkg::PH_STOP_HIGH: go_phase(i2cms_pkg::PH_STOP_REL, 1'b1, 1'b1);
          i2cms_pkg::PH_WR_LOW:    go_phase(i2cms_pkg::PH_WR_HIGH, 1'b1, sda_d);
          i2cms_pkg::PH_WR_HIGH: begin
            sreg  = {sreg[i2cms_pkg::DATA_BITS-2:0], 1'b0};
            nbits = nbits + 4'd1;
            if (nbits >= i2cms_pkg::DATA_BITS)
              go_phase(i2cms_pkg::PH_ACK_LOW, 1'b0, 1'b1);
            else
              go_phase(i2cms_pkg::PH_WR_LOW, 1'b0, sreg[i2cms_pkg::DATA_BITS-1]);
          end
          i2cms_pkg::PH_ACK_LOW:   go_phase(i2cms_pkg::PH_ACK_HIGH, 1'b1, 1'b1);
          i2cms_pkg::PH_ACK_HIGH:  go_phase(i2cms_pkg::PH_ACK_POLL, 1'b1, 1'b1);
          i2cms_pkg::PH_RD_LOW:    go_phase(i2cms_pkg::PH_RD_HIGH, 1'b1, 1'b1);
          i2cms_pkg::PH_RD_HIGH: begin
            sreg  = {sreg[i2cms_pkg::DATA_BITS-2:0], it.sda_in};
            nbits = nbits + 4'd1;
            if (nbits >= i2cms_pkg::DATA_BITS) begin
              last_rd = sreg;
              go_phase(i2cms_pkg::PH_RACK_LOW, 1'b0, nack_p);
            end else begin
              go_phase(i2cms_pkg::PH_RD_LOW, 1'b0, 1'b1);
            end
          end
          i2cms_pkg::PH_RACK_LOW:  go_phase(i2cms_pkg::PH_RACK_HIGH, 1'b1, sda_d);
          i2cms_pkg::PH_RACK_HIGH: go_phase(i2cms_pkg::PH_RACK_END, 1'b0, sda_d);
          default: begin
            // Stop release and acknowledge end both complete the command.
            ph   = i2cms_pkg::PH_IDLE;
            tcnt = '0;
            done = 1'b1;
          end
        endcase
      end
    end
    r.scl_level = scl_d;
    r.sda_level = sda_d;
    r.busy_res  = (ph != i2cms_pkg::PH_IDLE);
    r.done_res  = done;
    r.read_data = last_rd;
    r.no_ack    = noack;
    return r;
  endfunction

  // Queues one bus transfer: start, address byte, a few data bytes, stop.
  // Now and then a lone command stands in for it, breaking the usual order.
  function automatic void plan_transfer();
    i2cms_pkg::item_t t;
    int               n;
    logic             rd;
    if ($urandom_range(0, 9) == 0) begin
      t = rnd_item();
      t.command = 3'($urandom_range(i2cms_pkg::CMD_START, i2cms_pkg::CMD_READ));
      cmd_plan.push_back(t);
      return;
    end
    rd = $urandom_range(0, 1);
    n  = $urandom_range(1, 4);
    t = rnd_item();
    t.command = i2cms_pkg::CMD_START;
    cmd_plan.push_back(t);
    t = rnd_item();
    t.command = i2cms_pkg::CMD_WRITE;
    t.write_data[0] = rd;
    cmd_plan.push_back(t);
    for (int i = 0; i < n; i++) begin
      t = rnd_item();
      t.command = rd ? i2cms_pkg::CMD_READ : i2cms_pkg::CMD_WRITE;
      if (rd) t.send_nack = (i == n - 1) ? 1'b1 : ($urandom_range(0, 7) == 0);
      cmd_plan.push_back(t);
    end
    t = rnd_item();
    t.command = i2cms_pkg::CMD_STOP;
    cmd_plan.push_back(t);
  endfunction

  // Picks the next tick from the predicted state: mostly planned commands while idle,
  // mostly empty ticks while busy, and a slave that acks or not during polls.
  function automatic i2cms_pkg::item_t next_tick();
    i2cms_pkg::item_t t;
    t = rnd_item();
    t.command = i2cms_pkg::CMD_NONE;
    if (ph == i2cms_pkg::PH_IDLE) begin
      if (cmd_plan.size() == 0) plan_transfer();
      if ($urandom_range(0, 4) == 0) begin
        t.command = $urandom_range(0, 1) ? i2cms_pkg::CMD_NONE :
                    3'($urandom_range(CMD_RSVD5, CMD_RSVD7));
      end else begin
        t = cmd_plan.pop_front();
        t.sda_in = $urandom_range(0, 1);
        if (t.command == i2cms_pkg::CMD_WRITE)
          slave_ok = ($urandom_range(0, 99) >= nak_pct);
      end
    end else begin
      if ($urandom_range(0, 9) == 0) t.command = 3'($urandom_range(0, 7));
      if (ph == i2cms_pkg::PH_ACK_POLL) t.sda_in = slave_ok ? $urandom_range(0, 1) : 1'b1;
    end
    return t;
  endfunction

  // Offers one tick item and records the expected levels when it is taken.
  task automatic send_tick(i2cms_pkg::item_t it, logic typed, i2cms_pkg::result_t want);
    int                 gap;
    i2cms_pkg::result_t r;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    item <= it;
    do @(posedge clk); while (full);
    r = sequencer_tick(it);
    levels_q.push_back(typed ? want : r);
  endtask

  // Holds the sender until every expected result has come back.
  task automatic settle();
    @(negedge clk);
    push <= 1'b0;
    while (levels_q.size() != 0) @(posedge clk);
  endtask

  // Runs empty ticks until the predicted sequencer is idle; low SDA ends any ACK poll.
  task automatic drain();
    i2cms_pkg::item_t t;
    while (ph != i2cms_pkg::PH_IDLE) begin
      t = rnd_item();
      t.command = i2cms_pkg::CMD_NONE;
      t.sda_in  = 1'b0;
      send_tick(t, 1'b0, '0);
    end
  endtask

  // One configuration access: a write updates the predicted register, a read is checked.
  task automatic apb_xfer(logic wr, logic idx, logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wr ? data : '0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (!wr)                                    check_field("prdata", data, prdata);
    else if (idx == i2cms_pkg::REG_HALF_PERIOD) half_cfg = data[7:0];
    else                                        limit_cfg = data[15:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_regs(logic [7:0] half, logic [15:0] limit);
    apb_xfer(1'b1, i2cms_pkg::REG_HALF_PERIOD, {24'h0, half});
    apb_xfer(1'b1, i2cms_pkg::REG_ACK_WAIT, {16'h0, limit});
    apb_xfer(1'b0, i2cms_pkg::REG_HALF_PERIOD, {24'h0, half});
    apb_xfer(1'b0, i2cms_pkg::REG_ACK_WAIT, {16'h0, limit});
  endtask

  function automatic dir_row_t mk_row(logic [2:0] cmd, logic [7:0] data, logic nack, logic sda,
                                      logic [2:0] busy_cmd, logic typed,
                                      i2cms_pkg::result_t want);
    dir_row_t row;
    row.first.command    = cmd;
    row.first.write_data = data;
    row.first.send_nack  = nack;
    row.first.sda_in     = sda;
    row.busy_cmd         = busy_cmd;
    row.typed            = typed;
    row.want             = want;
    return row;
  endfunction

  // Result side: random pop stalls, each result checked against the oldest expectation.
  initial begin : result_sink
    i2cms_pkg::result_t want;
    int                 gap;
    wait (rst == 1'b0);
    forever begin
      gap = pick_gap();
      @(negedge clk);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (levels_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("%0t result with no expectation waiting", $realtime);
      end else begin
        want = levels_q.pop_front();
        check_field("scl_level", want.scl_level, result.scl_level);
        check_field("sda_level", want.sda_level, result.sda_level);
        check_field("busy_res",  want.busy_res,  result.busy_res);
        check_field("done_res",  want.done_res,  result.done_res);
        check_field("read_data", want.read_data, result.read_data);
        check_field("no_ack",    want.no_ack,    result.no_ack);
      end
    end
  end

  // Stimulus: reset, register checks, directed table, then random sections.
  initial begin : stimulus
    dir_row_t         dir_rows [15];
    i2cms_pkg::item_t t;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Registers come out of reset at their documented values.
    apb_xfer(1'b0, i2cms_pkg::REG_HALF_PERIOD, {24'h0, i2cms_pkg::HALF_PERIOD_RESET});
    apb_xfer(1'b0, i2cms_pkg::REG_ACK_WAIT, {16'h0, i2cms_pkg::ACK_WAIT_RESET});

    // Shortest timing so each directed command finishes in the fewest ticks.
    set_regs(8'd1, 16'd1);
    dir_rows = '{
      mk_row(i2cms_pkg::CMD_NONE, 8'h00, 1'b0, 1'b0, i2cms_pkg::CMD_NONE, 1'b1,
             IDLE_RELEASED),
      mk_row(CMD_RSVD7, 8'hFF, 1'b1, 1'b1, i2cms_pkg::CMD_NONE, 1'b1, IDLE_RELEASED),
      mk_row(CMD_RSVD5, 8'h55, 1'b0, 1'b1, i2cms_pkg::CMD_NONE, 1'b1, IDLE_RELEASED),
      mk_row(CMD_RSVD6, 8'hAA, 1'b1, 1'b0, i2cms_pkg::CMD_NONE, 1'b1, IDLE_RELEASED),
      mk_row(i2cms_pkg::CMD_START, 8'h00, 1'b0, 1'b1, i2cms_pkg::CMD_START, 1'b1,
             '{1'b1, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}),
      mk_row(i2cms_pkg::CMD_STOP, 8'h00, 1'b0, 1'b1, i2cms_pkg::CMD_STOP, 1'b1,
             '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}),
      // No ack from the slave: timeout, no_ack set and a stop issued.
      mk_row(i2cms_pkg::CMD_WRITE, 8'hFF, 1'b0, 1'b1, i2cms_pkg::CMD_WRITE, 1'b1,
             '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}),
      // A new write clears no_ack; the slave acks at the first poll.
      mk_row(i2cms_pkg::CMD_WRITE, 8'h00, 1'b1, 1'b0, i2cms_pkg::CMD_READ, 1'b1,
             '{1'b0, 1'b0, 1'b1, 1'b0, 8'h00, 1'b0}),
      mk_row(i2cms_pkg::CMD_READ, 8'h00, 1'b0, 1'b1, i2cms_pkg::CMD_WRITE, 1'b1,
             '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0}),
      mk_row(i2cms_pkg::CMD_READ, 8'hFF, 1'b1, 1'b0, CMD_RSVD7, 1'b0, '0),
      mk_row(i2cms_pkg::CMD_WRITE, 8'h80, 1'b0, 1'b1, i2cms_pkg::CMD_START, 1'b0, '0),
      mk_row(i2cms_pkg::CMD_WRITE, 8'h01, 1'b1, 1'b0, i2cms_pkg::CMD_STOP, 1'b0, '0),
      mk_row(i2cms_pkg::CMD_START, 8'h3C, 1'b1, 1'b0, i2cms_pkg::CMD_NONE, 1'b0, '0),
      mk_row(i2cms_pkg::CMD_READ, 8'hC3, 1'b0, 1'b0, i2cms_pkg::CMD_READ, 1'b0, '0),
      mk_row(i2cms_pkg::CMD_STOP, 8'h00, 1'b1, 1'b1, i2cms_pkg::CMD_NONE, 1'b0, '0)
    };
    foreach (dir_rows[i]) begin
      send_tick(dir_rows[i].first, dir_rows[i].typed, dir_rows[i].want);
      // Follow-up ticks carry a command that must be ignored while busy.
      while (ph != i2cms_pkg::PH_IDLE) begin
        t = dir_rows[i].first;
        t.command    = dir_rows[i].busy_cmd;
        t.write_data = ~t.write_data;
        t.send_nack  = ~t.send_nack;
        send_tick(t, 1'b0, '0);
      end
    end

    // Random sections, each with its own register values and stall pattern.
    foreach (bus_modes[m]) begin
      settle();
      set_regs(bus_modes[m].half, bus_modes[m].limit);
      nak_pct    = bus_modes[m].nak_pct;
      stall_free = bus_modes[m].calm;
      cmd_plan.delete();
      for (int n = 0; n < bus_modes[m].ticks; n++) begin
        if (n == bus_modes[m].ticks / 2) settle();
        send_tick(next_tick(), 1'b0, '0);
      end
      drain();
    end

    settle();
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin : watchdog
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
